// File: rtl/core/rpte_pkg.sv
// shared types, codes and helpers of the regex pattern token expander
package rpte_pkg;

  localparam int NUM_REGS     = 7;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);
  localparam int MAX_SPAN_DEF = 31;

  localparam logic [7:0] REG_RESET [NUM_REGS] = '{8'd21, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ANY       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PLUS      = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_QUESTION  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_STAR      = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ALTERNATE = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_OPEN      = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_CLOSE     = REG_IDX_W'(6);

  // pattern characters
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_DASH     = 8'h2d;
  localparam logic [7:0] CH_D        = 8'h64;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_QUESTION = 8'h3f;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_BAR      = 8'h7c;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;

  localparam logic [7:0] TOK_TERM = 8'h00;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ESCAPE = 2'd1,
    ST_BAD_RANGE  = 2'd2,
    ST_TOO_WIDE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_RANGE  = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_OPEN,
    S_MEMBER,
    S_ALT,
    S_CLOSE,
    S_SINGLE,
    S_FINISH,
    S_TERM
  } state_t;

  typedef enum logic [1:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_INC
  } uop_t;

  typedef struct packed {
    uop_t       op;
    logic [7:0] lo;
    logic [7:0] hi;
  } ucmd_t;

  typedef struct packed {
    logic [7:0] cur;     // current range member
    logic       at_end;  // current member equals range end
    logic       borrow;  // range start above range end
    logic       wide;    // member count above the span limit
  } ustat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] token;
    logic       last;
    status_t    status;
  } emit_t;

  typedef struct packed {
    logic [7:0] any;
    logic [7:0] plus;
    logic [7:0] question;
    logic [7:0] star;
    logic [7:0] alternate;
    logic [7:0] open;
    logic [7:0] close;
  } codes_t;

  function automatic logic [7:0] map_plain(input logic [7:0] b, input codes_t codes);
    logic [7:0] r;
    case (b)
      CH_DOT:      r = codes.any;
      CH_PLUS:     r = codes.plus;
      CH_QUESTION: r = codes.question;
      CH_STAR:     r = codes.star;
      CH_BAR:      r = codes.alternate;
      CH_LPAREN:   r = codes.open;
      CH_RPAREN:   r = codes.close;
      default:     r = b;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/rpte_range_unit.sv
// shared range unit: member counter with one adder for span check and stepping
module rpte_range_unit import rpte_pkg::*; #(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic   clk,
  input  ucmd_t  cmd,
  output ustat_t stat
);

  logic [7:0] cur;
  logic [7:0] hi;
  logic [7:0] opa;
  logic [7:0] opb;
  logic [8:0] sum;

  // inc: cur + 1, otherwise hi - cur
  always_comb begin
    case (cmd.op)
      UOP_INC: begin
        opa = cur;
        opb = 8'h00;
      end
      default: begin
        opa = hi;
        opb = ~cur;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, opb} + 9'd1;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      UOP_LOAD: begin
        cur <= cmd.lo;
        hi  <= cmd.hi;
      end
      UOP_INC: cur <= sum[7:0];
      default: ;
    endcase
  end

  assign stat.cur    = cur;
  assign stat.at_end = (cur == hi);
  assign stat.borrow = ~sum[8];
  assign stat.wide   = (sum[7:0] >= 8'(MAX_SPAN));

endmodule

// File: rtl/core/rpte_seq.sv
// parse sequencer: decodes pattern bytes and steps token emission
module rpte_seq import rpte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  codes_t     codes,
  input  logic       out_free,
  output emit_t      emit,
  output ucmd_t      ucmd,
  input  ustat_t     ustat
);

  state_t     state, state_next;
  mode_t      mode, mode_next;
  logic [1:0] range_pos, range_pos_next;
  logic [7:0] range_bytes [3];
  logic       rb_we;
  logic [7:0] byte_reg, byte_next;
  logic       last_reg, last_next;
  logic [7:0] hold_tok, hold_tok_next;
  status_t    hold_st, hold_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_NORMAL;
      range_pos <= 2'd0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      range_pos <= range_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_reg <= byte_next;
    last_reg <= last_next;
    hold_tok <= hold_tok_next;
    hold_st  <= hold_st_next;
    if (rb_we) begin
      range_bytes[range_pos] <= byte_reg;
    end
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    range_pos_next = range_pos;
    byte_next      = byte_reg;
    last_next      = last_reg;
    hold_tok_next  = hold_tok;
    hold_st_next   = hold_st;
    rb_we          = 1'b0;
    in_ready       = 1'b0;
    emit           = '{valid: 1'b0, token: TOK_TERM, last: 1'b0, status: ST_OK};
    ucmd           = '{op: UOP_NONE, lo: 8'h00, hi: 8'h00};

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          byte_next  = in_byte;
          last_next  = in_end;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_FINISH;
        case (mode)
          MODE_NORMAL: begin
            if (byte_reg == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else if (byte_reg == CH_LBRACKET) begin
              mode_next      = MODE_RANGE;
              range_pos_next = 2'd0;
            end else begin
              hold_tok_next = map_plain(byte_reg, codes);
              hold_st_next  = ST_OK;
              state_next    = S_SINGLE;
            end
          end
          MODE_ESCAPE: begin
            mode_next = MODE_NORMAL;
            if (byte_reg == CH_D) begin
              ucmd       = '{op: UOP_LOAD, lo: CH_ZERO, hi: CH_NINE};
              state_next = S_CHECK;
            end else begin
              hold_tok_next = byte_reg;
              hold_st_next  = ST_OK;
              state_next    = S_SINGLE;
            end
          end
          MODE_RANGE: begin
            if (range_pos != 2'd3) begin
              rb_we          = 1'b1;
              range_pos_next = range_pos + 2'd1;
            end else begin
              range_pos_next = 2'd0;
              mode_next      = MODE_NORMAL;
              if (byte_reg != CH_RBRACKET || range_bytes[1] != CH_DASH ||
                  range_bytes[0] <= CH_SPACE) begin
                hold_tok_next = TOK_TERM;
                hold_st_next  = ST_BAD_RANGE;
                mode_next     = MODE_SKIP;
                state_next    = S_SINGLE;
              end else begin
                ucmd       = '{op: UOP_LOAD, lo: range_bytes[0], hi: range_bytes[2]};
                state_next = S_CHECK;
              end
            end
          end
          default: ;
        endcase
      end

      // unit holds start and end; its adder gives end - start
      S_CHECK: begin
        if (ustat.borrow) begin
          hold_tok_next = TOK_TERM;
          hold_st_next  = ST_BAD_RANGE;
          mode_next     = MODE_SKIP;
          state_next    = S_SINGLE;
        end else if (ustat.wide) begin
          hold_tok_next = TOK_TERM;
          hold_st_next  = ST_TOO_WIDE;
          mode_next     = MODE_SKIP;
          state_next    = S_SINGLE;
        end else begin
          state_next = S_OPEN;
        end
      end

      S_OPEN: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, token: codes.open, last: 1'b0, status: ST_OK};
          state_next = S_MEMBER;
        end
      end

      S_MEMBER: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, token: ustat.cur, last: 1'b0, status: ST_OK};
          state_next = ustat.at_end ? S_CLOSE : S_ALT;
        end
      end

      S_ALT: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, token: codes.alternate, last: 1'b0, status: ST_OK};
          ucmd       = '{op: UOP_INC, lo: 8'h00, hi: 8'h00};
          state_next = S_MEMBER;
        end
      end

      S_CLOSE: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, token: codes.close, last: ~last_reg, status: ST_OK};
          state_next = S_FINISH;
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, token: hold_tok, last: ~last_reg, status: hold_st};
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!last_reg) begin
          state_next = S_IDLE;
        end else if (mode == MODE_ESCAPE || mode == MODE_RANGE) begin
          if (out_free) begin
            emit = '{valid: 1'b1, token: TOK_TERM, last: 1'b0,
                     status: (mode == MODE_ESCAPE) ? ST_BAD_ESCAPE : ST_BAD_RANGE};
            state_next = S_TERM;
          end
        end else begin
          state_next = S_TERM;
        end
      end

      S_TERM: begin
        if (out_free) begin
          emit           = '{valid: 1'b1, token: TOK_TERM, last: 1'b1, status: ST_OK};
          mode_next      = MODE_NORMAL;
          range_pos_next = 2'd0;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("token pushed while output register is full");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.status != ST_OK |-> emit.token == TOK_TERM && emit.last != last_reg)
    else $error("error result has wrong token or last flag");

  a_term_resets: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.last && last_reg |=> mode == MODE_NORMAL && range_pos == 2'd0)
    else $error("pattern end did not return parser to normal");

  a_term_token: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.last && last_reg |-> emit.token == TOK_TERM && emit.status == ST_OK)
    else $error("final result of a pattern is not the terminator");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE && !in_ready)
    else $error("accepted byte not decoded next");
`endif

endmodule

// File: rtl/core/regex_pattern_token_expander.sv
// Regex pattern token expander: takes one pattern byte per transaction on the
// s_axis side and emits token codes on the m_axis side, one per cycle at most.
// A plain byte goes through accept, decode, emit and wrap-up steps; a range
// or \d is expanded member by member, as the sequencer emits one token per
// cycle through a single output register while the output does not stall,
// and steps members with one shared adder. The pattern end adds a terminator;
// an error that it reports goes out in the wrap-up step. s_axis_tready is
// high only while the sequencer is idle; an output stall holds the sequencer.
// No clearing pass is needed after reset.
module regex_pattern_token_expander import rpte_pkg::*; #(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] pattern_byte
  input  logic                 s_axis_tlast,   // pattern_end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] token
  output logic                 m_axis_tlast,   // token_last
  output logic [1:0]           m_axis_tuser,   // [1:0] status
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] code_regs [NUM_REGS];
  codes_t     codes;
  emit_t      emit;
  ucmd_t      ucmd;
  ustat_t     ustat;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        code_regs[i] <= REG_RESET[i];
      end
    end else if (cfg_we && cfg_index < REG_IDX_W'(NUM_REGS)) begin
      code_regs[cfg_index] <= cfg_data;
    end
  end

  assign codes = '{any:       code_regs[REG_ANY],
                   plus:      code_regs[REG_PLUS],
                   question:  code_regs[REG_QUESTION],
                   star:      code_regs[REG_STAR],
                   alternate: code_regs[REG_ALTERNATE],
                   open:      code_regs[REG_OPEN],
                   close:     code_regs[REG_CLOSE]};

  assign out_free = ~m_axis_tvalid | m_axis_tready;

  rpte_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .codes    (codes),
    .out_free (out_free),
    .emit     (emit),
    .ucmd     (ucmd),
    .ustat    (ustat)
  );

  rpte_range_unit #(
    .MAX_SPAN (MAX_SPAN)
  ) u_range (
    .clk  (clk),
    .cmd  (ucmd),
    .stat (ustat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_axis_tdata <= emit.token;
      m_axis_tlast <= emit.last;
      m_axis_tuser <= emit.status;
    end
  end

endmodule
